[rtl/f2fp12_pkg.sv]
// f2fp12_pkg: constants shared by the float32 to fp12 converter and its testbench
// no dependencies
package f2fp12_pkg;
  localparam int unsigned InWidth  = 32;
  localparam int unsigned OutWidth = 16;
  localparam logic [15:0] PosInf = 16'h07e0;
  localparam logic [15:0] NegInf = 16'hffe0;
  localparam logic [15:0] PosNan = 16'h07f1;
  localparam logic [15:0] NegNan = 16'hfff1;
  localparam logic [15:0] NegZero = 16'hf800;
endpackage

[rtl/float32_to_fp12_converter.sv]
// float32_to_fp12_converter: single-precision pattern to fp12 word, round to nearest even
// depends on f2fp12_pkg
// an accepted word passes through the input register, then the result register
// throughput: one word per cycle while the output is not stalled; the conversion is a short shift and increment
// between the two registers, and a result may wait in the output register while
// the next word is taken when the downstream side is stalled
// reset: rst_ni clears the valid flags only; payload registers are not reset
module float32_to_fp12_converter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [f2fp12_pkg::InWidth-1:0]  float_bits_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [f2fp12_pkg::OutWidth-1:0] fp12_word_o
);
  import f2fp12_pkg::*;

  logic        in_vld_q, out_vld_q;
  logic [31:0] in_q;
  logic [15:0] out_q, res_d;
  logic        adv_out, adv_in;

  assign adv_out    = !out_vld_q || out_ready_i;
  assign adv_in     = !in_vld_q || adv_out;
  assign in_ready_o = adv_in;
  assign out_valid_o = out_vld_q;
  assign fp12_word_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in)  in_vld_q  <= in_valid_i;
      if (adv_out) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) in_q <= float_bits_i;
    if (adv_out && in_vld_q)  out_q <= res_d;
  end

  // conversion
  logic        sgn;
  logic [7:0]  bexp;
  logic [22:0] man;
  logic [15:0] sfield;
  logic [15:0] inf_w;
  logic [29:0] sig;   // fraction and guard bits for the shift, with the hidden one for subnormals
  logic [2:0]  sh;    // subnormal shift 0..5
  logic        sub;
  logic [29:0] shd;
  logic [5:0]  frac;
  logic        lsb, rnd, sticky;
  logic [5:0]  ef;    // biased exponent
  logic [6:0]  ef_r;

  always_comb begin
    sgn    = in_q[31];
    bexp   = in_q[30:23];
    man    = in_q[22:0];
    sfield = sgn ? NegZero : 16'h0000;
    inf_w  = sgn ? NegInf : PosInf;
    // e = bexp-127; subnormal when bexp in 91..96, shift = 96-bexp
    sub    = (bexp <= 8'd96);
    sh     = 3'(8'd96 - bexp);
    sig    = sub ? ({1'b1, man, 6'd0} >> (3'd1 + sh)) : {1'b0, man, 6'd0};
    shd    = sig;
    // result fraction from bits 28..24, round bit 23, sticky below
    lsb    = shd[24];
    rnd    = shd[23];
    sticky = |shd[22:0];
    frac   = {1'b0, shd[28:24]} + 6'(rnd && (sticky || lsb));
    ef     = sub ? 6'd1 : 6'(bexp - 8'd96);
    ef_r   = {1'b0, ef} + 7'(frac[5] && !sub);
    if (bexp <= 8'd90) begin
      res_d = sfield;
    end else if (bexp == 8'hff) begin
      res_d = (man == 23'd0) ? inf_w : (sgn ? NegNan : PosNan);
    end else if (bexp > 8'd158) begin
      res_d = inf_w;
    end else if (sub && !frac[5]) begin
      res_d = sfield | {11'd0, frac[4:0]};
    end else if (ef_r >= 7'd63) begin
      res_d = inf_w;
    end else begin
      res_d = sfield | {5'd0, ef_r[5:0], 5'd0} | {11'd0, frac[4:0]};
    end
  end
endmodule

[rtl/f2fp12_checker.sv]
// f2fp12_checker: port-level checks for the fp12 converter
// bound into float32_to_fp12_converter
module f2fp12_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] fp12_word_o
);
  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fp12_word_o))
    else $error("stalled word changed");
  // sign field is five equal bits
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fp12_word_o[15:11] == 5'h00 || fp12_word_o[15:11] == 5'h1f))
    else $error("bad sign field");
  // free output side never blocks input
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output free");
  // an accepted word passes through the input and result registers to the output when unstalled
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o ##1 out_ready_i |=> out_valid_o)
    else $error("word lost");
endmodule

bind float32_to_fp12_converter f2fp12_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .fp12_word_o(fp12_word_o)
);

[tb/tb_float32_to_fp12_converter.sv]
// tb_float32_to_fp12_converter: self-checking testbench for the float32 to fp12 converter
// drives single-precision words, predicts fp12 results in a scoreboard class, checks in order
// depends on f2fp12_pkg and float32_to_fp12_converter
`timescale 1ns / 1ps

module tb_float32_to_fp12_converter;
  import f2fp12_pkg::*;

  class fp12_scoreboard;
    logic [15:0] pending_words[$];
    int unsigned errors = 0;

    function automatic logic [15:0] fp12_of(logic [31:0] bits);
      logic        sgn;
      logic [7:0]  bexp;
      logic [31:0] mant;
      int          e;
      logic [15:0] sign_field;
      logic [15:0] inf_word;
      logic        sub;
      logic        lsb, rnd, sticky;
      logic [5:0]  frac;
      logic [15:0] expf;
      sgn = bits[31];
      bexp = bits[30:23];
      mant = {bits[22:0], 9'b0};
      e = int'(bexp) - 127;
      sign_field = sgn ? NegZero : 16'h0000;
      inf_word = sgn ? NegInf : PosInf;
      sub = 1'b0;
      if (e <= -37) return sign_field;
      if (bexp == 8'hff) return (mant == 0) ? inf_word : (sgn ? NegNan : PosNan);
      if (e > 31) return inf_word;
      if (e <= -31) begin
        // hidden one enters the fraction for fp12 subnormals
        sub = 1'b1;
        mant = {1'b1, mant[31:1]} >> (-31 - e);
        e = -30;
      end
      lsb = mant[27];
      rnd = mant[26];
      sticky = |mant[25:0];
      frac = {1'b0, mant[31:27]};
      if (rnd && (sticky || lsb)) frac = frac + 6'd1;
      if (frac[5]) begin
        frac = 6'd0;
        if (sub) sub = 1'b0;
        else e = e + 1;
      end
      if (e >= 32) return inf_word;
      expf = sub ? 16'h0 : {5'b0, 6'(e + 31), 5'b0};
      return sign_field | expf | {11'b0, frac[4:0]};
    endfunction

    function void note_input(logic [31:0] bits);
      pending_words.push_back(fp12_of(bits));
    endfunction

    function void check_word(logic [15:0] got);
      logic [15:0] want;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
        $display("%0t: fp12_word expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] float_bits_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] fp12_word_o;

  fp12_scoreboard sb = new();
  logic [31:0] directed_words[$];
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;
  bit          sending_done = 1'b0;
  int unsigned cycle_count = 0;
  localparam int unsigned RandomWords = 2000;
  localparam int unsigned CycleLimit = 200000;

  float32_to_fp12_converter dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** float32_to_fp12_converter: FAILED **");
      $finish;
    end
  end

  // scoreboard hooks on accepted words
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(float_bits_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(fp12_word_o);
  end

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int unsigned pick;
    w = $urandom();
    pick = $urandom_range(0, 9);
    // bias exponents toward the fp12 range and its edges, and low mantissa bits to all zeros or all ones
    if (pick < 5) w[30:23] = 8'($urandom_range(127 - 38, 127 + 32));
    else if (pick == 5) w[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
    else if (pick == 6) w[21:0] = $urandom_range(0, 1) ? 22'h0 : 22'h3fffff;
    return w;
  endfunction

  // called at a falling edge; valid stays high across back-to-back words
  task automatic send_word(logic [31:0] bits);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    float_bits_i <= bits;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver: random stall bursts, one long hold-off early on
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_off = 1'b0;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    directed_words = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h7f800000,
                       32'hff800000, 32'h7fc00000, 32'hffffffff, 32'h7f800001,
                       32'h4f800000, 32'h4f7fffff, 32'h4f7c0000, 32'h4f7bffff,
                       32'h2d000000, 32'h2d800000, 32'hadc00000, 32'h30000000,
                       32'h2fffffff, 32'h30040000, 32'h300c0000, 32'h3f840000,
                       32'h3f8c0000, 32'h3f840001, 32'h7f7fffff, 32'h3f800000,
                       32'h55555555};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_words[i]) send_word(directed_words[i]);
    hold_off = 1'b1;
    for (int unsigned n = 0; n < RandomWords; n++) begin
      if (n == RandomWords - 300) calm = 1'b1;
      send_word(random_word());
    end
    in_valid_i <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_words.size() == 0)
      $display("** float32_to_fp12_converter: PASSED **");
    else
      $display("** float32_to_fp12_converter: FAILED **");
    $finish;
  end
endmodule

[float32_to_fp12_converter.f]
rtl/f2fp12_pkg.sv
rtl/float32_to_fp12_converter.sv
rtl/f2fp12_checker.sv
tb/tb_float32_to_fp12_converter.sv
